// ----- rtl/ifcc_pkg.sv -----
`timescale 1ns / 1ps
package ifcc_pkg;

  localparam int HEADER_BYTES = 5;
  localparam int LENGTH_POS   = 2;
  localparam int WINDOW       = 100;

  localparam int POS_W = 9;
  localparam int CNT_W = 7;
  localparam int LEN_W = 8;

  localparam logic [POS_W-1:0] HDR_LAST  = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] CHK_HI    = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] CHK_LO    = POS_W'(HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] PAY_BIAS  = POS_W'(HEADER_BYTES + 1);
  localparam logic [POS_W-1:0] LEN_AT    = POS_W'(LENGTH_POS);
  localparam logic [CNT_W-1:0] WINDOW_C  = CNT_W'(WINDOW);

  localparam logic [7:0]  CRC8_POLY_REFL = 8'h8c;
  localparam logic [15:0] CRC16_POLY     = 16'h1021;

  typedef enum logic [1:0] {
    VERDICT_GOOD     = 2'd0,
    VERDICT_HDR_FAIL = 2'd1,
    VERDICT_PAY_FAIL = 2'd2
  } verdict_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [LEN_W-1:0]  length;
  } evt_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC8_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC16_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/ifcc_in_if.sv -----
`timescale 1ns / 1ps
interface ifcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- rtl/ifcc_out_if.sv -----
`timescale 1ns / 1ps
interface ifcc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic [6:0] good_count;
  logic [6:0] lost_count;
  logic [7:0] payload_bytes;

  modport source (output valid, output verdict, output good_count, output lost_count,
                  output payload_bytes, input ready);
  modport sink   (input valid, input verdict, input good_count, input lost_count,
                  input payload_bytes, output ready);
endinterface

// ----- rtl/ifcc_front.sv -----
`timescale 1ns / 1ps
module ifcc_front (
  input  logic             clk,
  input  logic             rst,
  ifcc_in_if.sink          rx,
  input  logic             full,
  output logic             push,
  output ifcc_pkg::evt_t   evt
);

  logic [ifcc_pkg::POS_W-1:0] pos, pos_next;
  logic                       active, active_next;
  logic [7:0]                 hcrc, hcrc_next;
  logic [15:0]                pcrc, pcrc_next;
  logic [15:0]                expc, expc_next;
  logic [ifcc_pkg::LEN_W-1:0] len, len_next;

  logic                       acc;
  logic                       live;
  logic [ifcc_pkg::POS_W-1:0] p;
  logic [7:0]                 hc;
  logic [15:0]                pc;
  logic [15:0]                ec;
  logic [ifcc_pkg::LEN_W-1:0] ln;
  logic [15:0]                crc16_new;

  assign rx.ready = !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      active <= 1'b0;
      hcrc   <= '0;
      pcrc   <= '0;
      expc   <= '0;
      len    <= '0;
    end else begin
      pos    <= pos_next;
      active <= active_next;
      hcrc   <= hcrc_next;
      pcrc   <= pcrc_next;
      expc   <= expc_next;
      len    <= len_next;
    end
  end

  always_comb begin
    acc  = rx.valid && rx.ready;
    live = rx.frame_start || active;
    // a start byte restarts all running checks
    p  = rx.frame_start ? '0 : pos;
    hc = rx.frame_start ? '0 : hcrc;
    pc = rx.frame_start ? '0 : pcrc;
    ec = rx.frame_start ? '0 : expc;
    ln = rx.frame_start ? '0 : len;
    crc16_new = ifcc_pkg::crc16_step(pc, rx.rx_byte);

    pos_next    = pos;
    active_next = active;
    hcrc_next   = hcrc;
    pcrc_next   = pcrc;
    expc_next   = expc;
    len_next    = len;
    push        = 1'b0;
    evt.verdict = ifcc_pkg::VERDICT_GOOD;
    evt.length  = ln;

    if (acc && live) begin
      active_next = 1'b1;
      pos_next    = p + 1'b1;
      hcrc_next   = hc;
      pcrc_next   = pc;
      expc_next   = ec;
      len_next    = ln;
      if (p < ifcc_pkg::HDR_LAST) begin
        if (p == ifcc_pkg::LEN_AT) begin
          len_next = rx.rx_byte;
        end
        hcrc_next = ifcc_pkg::crc8_step(hc, rx.rx_byte);
      end else if (p == ifcc_pkg::HDR_LAST) begin
        if (p == ifcc_pkg::LEN_AT) begin
          len_next = rx.rx_byte;
        end
        evt.length = len_next;
        if (rx.rx_byte != hc) begin
          push        = 1'b1;
          evt.verdict = ifcc_pkg::VERDICT_HDR_FAIL;
          active_next = 1'b0;
        end
      end else if (p == ifcc_pkg::CHK_HI) begin
        expc_next = {rx.rx_byte, 8'h00};
      end else if (p == ifcc_pkg::CHK_LO) begin
        expc_next = {ec[15:8], rx.rx_byte};
        if (ln == '0) begin
          push        = 1'b1;
          evt.verdict = (pc == expc_next) ? ifcc_pkg::VERDICT_GOOD
                                          : ifcc_pkg::VERDICT_PAY_FAIL;
          active_next = 1'b0;
        end
      end else begin
        pcrc_next = crc16_new;
        if ((p - ifcc_pkg::PAY_BIAS) >= {1'b0, ln}) begin
          push        = 1'b1;
          evt.verdict = (crc16_new == ec) ? ifcc_pkg::VERDICT_GOOD
                                          : ifcc_pkg::VERDICT_PAY_FAIL;
          active_next = 1'b0;
        end
      end
    end
  end

endmodule

// ----- rtl/ifcc_queue.sv -----
`timescale 1ns / 1ps
module ifcc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ifcc_pkg::evt_t   wr_evt,
  input  logic             pop,
  output ifcc_pkg::evt_t   rd_evt,
  output logic             full,
  output logic             empty
);

  ifcc_pkg::evt_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign full   = (count == 2'd2);
  assign empty  = (count == 2'd0);
  assign rd_evt = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop)) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty)) else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2) else $error("queue count out of range");

endmodule

// ----- rtl/ifcc_back.sv -----
`timescale 1ns / 1ps
module ifcc_back (
  input  logic             clk,
  input  logic             rst,
  input  ifcc_pkg::evt_t   evt,
  input  logic             empty,
  output logic             pop,
  ifcc_out_if.source       result
);

  logic [ifcc_pkg::WINDOW-1:0] hist;
  logic [ifcc_pkg::CNT_W-1:0]  fill, fill_next;
  logic [ifcc_pkg::CNT_W-1:0]  good, good_next;
  logic                        new_bit;
  logic                        res_valid;

  assign pop       = !empty && (!res_valid || result.ready);
  assign new_bit   = (evt.verdict == ifcc_pkg::VERDICT_GOOD);
  // the bit leaving the window is zero until the window has filled
  assign good_next = good + ifcc_pkg::CNT_W'(new_bit)
                   - ifcc_pkg::CNT_W'(hist[ifcc_pkg::WINDOW-1]);
  assign fill_next = (fill == ifcc_pkg::WINDOW_C) ? fill : fill + 1'b1;
  assign result.valid = res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist      <= '0;
      fill      <= '0;
      good      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (pop) begin
        hist      <= (hist << 1) | ifcc_pkg::WINDOW'(new_bit);
        fill      <= fill_next;
        good      <= good_next;
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.verdict       <= evt.verdict;
      result.good_count    <= good_next;
      result.lost_count    <= fill_next - good_next;
      result.payload_bytes <= evt.length;
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= ifcc_pkg::WINDOW_C) else $error("history fill beyond window");

  a_good_le_fill: assert property (@(posedge clk) disable iff (rst)
    good <= fill) else $error("good count exceeds history fill");

  a_pop_shows: assert property (@(posedge clk) disable iff (rst)
    pop |=> (res_valid && fill != '0)) else $error("popped event not presented");

endmodule

// ----- rtl/imu_frame_crc_checker.sv -----
`timescale 1ns / 1ps
// Sensor frame checker.
// rx carries one frame byte per transaction; frame_start marks the first
// byte of a frame. Header bytes before the last are covered by CRC-8/MAXIM
// and checked against the last header byte; the header byte at LENGTH_POS
// gives the payload length; two check bytes (high first) follow, then the
// payload, covered by CRC-16/XMODEM.
// result carries one transaction per finished frame: verdict (good, header
// fail, payload fail), good and lost counts over the last WINDOW verdicts,
// and the payload length. A byte outside a frame is dropped, and a frame cut
// short by a new start gives no result.
// Throughput: one byte per cycle while rx.ready is high; the CRC update for a
// byte is computed combinationally, bit by bit, in the front parser. A
// frame's event is registered in the event queue, then in the output
// register, from which result presents it.
// A two-entry event queue sits between parser and output register, so rx
// keeps flowing while a result waits; rx.ready drops only when the queue is
// full because result has been stalled.
// Reset clears the frame state, the verdict history and both counts.
module imu_frame_crc_checker (
  input  logic         clk,
  input  logic         rst,
  ifcc_in_if.sink      rx,
  ifcc_out_if.source   result
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  ifcc_pkg::evt_t wr_evt;
  ifcc_pkg::evt_t rd_evt;

  ifcc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .full (full),
    .push (push),
    .evt  (wr_evt)
  );

  ifcc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_evt (wr_evt),
    .pop    (pop),
    .rd_evt (rd_evt),
    .full   (full),
    .empty  (empty)
  );

  ifcc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .evt    (rd_evt),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule
